// ===== rtl/core/ptd_pkg.sv =====
// Shared types and constants for the periodic task dispatcher.
package ptd_pkg;

    // Number of task slots that exist in hardware
    localparam int MAX_TASKS     = 6;
    // Default number of scanned tasks
    localparam int NUM_TASKS_DEF = 6;

    localparam int TIME_W  = 32;
    localparam int IDX_W   = 3;
    localparam int ADDR_W  = 3;

    // Register map
    localparam logic [ADDR_W-1:0] REG_ENABLE        = 3'd0;
    localparam logic [ADDR_W-1:0] REG_INTERVAL_FIRST = 3'd1;
    localparam logic [ADDR_W-1:0] REG_INTERVAL_LAST  = 3'd6;

    localparam logic [MAX_TASKS-1:0] ENABLE_RESET = 6'h3F;
    localparam logic [TIME_W-1:0]    LAST_TASK_RESET_RUN = 32'd200;

    typedef logic [TIME_W-1:0] time_word_t;
    typedef time_word_t [MAX_TASKS-1:0] time_array_t;

    localparam time_array_t INTERVAL_RESET = {
        32'd500, 32'd1, 32'd100, 32'd500, 32'd500, 32'd2
    };

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_SCAN
    } ptd_state_t;

endpackage

// ===== rtl/core/periodic_task_dispatcher_top.sv =====
// Periodic task dispatcher: scans task timers one per cycle and reports the due task.
//
// Usage
//   Input channel (s_valid/s_ready, s_now_ms): one transfer per millisecond tick
//   carrying the free-running time. The first transfer after reset latches the
//   launch time; later times are taken relative to it.
//   Result channel (m_valid/m_ready, m_task_due, m_task_index): one transfer per
//   input, naming the first enabled task at or after the scan position whose
//   elapsed time exceeds its interval, or none.
//   Configuration: cfg_we/cfg_addr/cfg_wdata, index 0 enable mask, 1..6 the
//   task intervals; other indexes are ignored. Write only while idle.
// Timing
//   One shared subtract-and-compare unit checks one task per cycle while scanning;
//   when the scan ends, the result register is loaded and s_ready returns in the
//   same cycle. The next input is taken even while the previous result is still
//   waiting in the output register.
// Reset and stall
//   aresetn (synchronous, active low) restores the default intervals, enable mask
//   and last-run times and clears launch and scan state. If the output register is
//   still full with m_ready low when a scan ends, the scan holds until it frees;
//   the dispatch is committed only then.
module periodic_task_dispatcher_top
    import ptd_pkg::*;
#(
    parameter int NUM_TASKS = NUM_TASKS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [TIME_W-1:0] s_now_ms,
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_task_due,
    output logic [IDX_W-1:0]  m_task_index,
    input  logic              cfg_we,
    input  logic [ADDR_W-1:0] cfg_addr,
    input  logic [TIME_W-1:0] cfg_wdata
);

    localparam logic [IDX_W-1:0] NUM_IDX  = IDX_W'(NUM_TASKS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_TASKS - 1);

    ptd_state_t            state_reg, state_next;
    logic [MAX_TASKS-1:0]  enable_reg;
    time_array_t           interval_reg;
    time_array_t           last_run_reg, last_run_next;
    logic                  launched_reg, launched_next;
    logic [TIME_W-1:0]     launch_reg, launch_next;
    logic [TIME_W-1:0]     rel_reg, rel_next;
    logic [IDX_W-1:0]      scan_pos_reg, scan_pos_next;
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic                  m_valid_reg, m_valid_next;
    logic                  due_reg, due_next;
    logic [IDX_W-1:0]      task_reg, task_next;

    // Shared compare unit signals
    logic [IDX_W-1:0]      rd_idx;
    logic                  idx_in_range;
    logic [TIME_W-1:0]     elapsed;
    logic                  hit;
    logic                  out_free;

    assign s_ready      = (state_reg == ST_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_task_due   = due_reg;
    assign m_task_index = task_reg;
    assign out_free     = !m_valid_reg || m_ready;

    // One task per cycle: wrapping elapsed time against its interval
    always_comb begin
        idx_in_range = (idx_reg < NUM_IDX);
        rd_idx       = idx_in_range ? idx_reg : '0;
        elapsed      = rel_reg - last_run_reg[rd_idx];
        hit          = idx_in_range && enable_reg[rd_idx] && (elapsed > interval_reg[rd_idx]);
    end

    // Sequencer: next state and datapath updates
    always_comb begin
        state_next    = state_reg;
        last_run_next = last_run_reg;
        launched_next = launched_reg;
        launch_next   = launch_reg;
        rel_next      = rel_reg;
        scan_pos_next = scan_pos_reg;
        idx_next      = idx_reg;
        m_valid_next  = m_valid_reg;
        due_next      = due_reg;
        task_next     = task_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    // Latch the launch time on the first transfer
                    if (!launched_reg) begin
                        launched_next = 1'b1;
                        launch_next   = s_now_ms;
                        rel_next      = '0;
                    end else begin
                        rel_next = s_now_ms - launch_reg;
                    end
                    idx_next   = scan_pos_reg;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (hit) begin
                    if (out_free) begin
                        last_run_next[rd_idx] = rel_reg;
                        scan_pos_next         = idx_reg;
                        m_valid_next          = 1'b1;
                        due_next              = 1'b1;
                        task_next             = idx_reg;
                        state_next            = ST_IDLE;
                    end
                end else if (!idx_in_range || idx_reg == LAST_IDX) begin
                    // Nothing due: report none and restart the scan at 0
                    if (out_free) begin
                        scan_pos_next = '0;
                        m_valid_next  = 1'b1;
                        due_next      = 1'b0;
                        task_next     = '0;
                        state_next    = ST_IDLE;
                    end
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Control and timer state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            launched_reg <= 1'b0;
            launch_reg   <= '0;
            scan_pos_reg <= '0;
            m_valid_reg  <= 1'b0;
            // last scanned task starts with a non-zero last-run time
            for (int k = 0; k < MAX_TASKS; k++) begin
                last_run_reg[k] <= (k == NUM_TASKS - 1) ? LAST_TASK_RESET_RUN : '0;
            end
        end else begin
            launched_reg <= launched_next;
            launch_reg   <= launch_next;
            scan_pos_reg <= scan_pos_next;
            m_valid_reg  <= m_valid_next;
            last_run_reg <= last_run_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        rel_reg  <= rel_next;
        idx_reg  <= idx_next;
        due_reg  <= due_next;
        task_reg <= task_next;
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg   <= ENABLE_RESET;
            interval_reg <= INTERVAL_RESET;
        end else if (cfg_we) begin
            if (cfg_addr == REG_ENABLE) begin
                enable_reg <= cfg_wdata[MAX_TASKS-1:0];
            end else if (cfg_addr inside {[REG_INTERVAL_FIRST:REG_INTERVAL_LAST]}) begin
                interval_reg[cfg_addr - REG_INTERVAL_FIRST] <= cfg_wdata;
            end
        end
    end

endmodule

// ===== dv/periodic_task_dispatcher_top_tb.sv =====
// Self-checking testbench for the periodic task dispatcher top level.
module periodic_task_dispatcher_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ptd_pkg::*;

    localparam int TASKS        = NUM_TASKS_DEF;
    localparam int TARGET_ITEMS = 1950;
    localparam int CYCLE_LIMIT  = 1000000;
    // covers the longest scan plus the output register
    localparam int SETTLE       = 12;
    localparam int HOLD_CYCLES  = 200;

    // index outside the register map, writes to it must be dropped
    localparam logic [ADDR_W-1:0] REG_UNUSED = 3'd7;

    typedef struct packed {
        logic             due;
        logic [IDX_W-1:0] idx;
    } dispatch_t;

    typedef enum bit {
        ROW_ITEM,
        ROW_WRITE
    } row_kind_t;

    // addr is only used by writes, value is the time on items
    typedef struct packed {
        row_kind_t        kind;
        logic [ADDR_W-1:0] addr;
        time_word_t       value;
        bit               typed;
        logic             due;
        logic [IDX_W-1:0] idx;
    } row_t;

    localparam int DIRECTED_ROWS = 24;
    localparam row_t DIRECTED [DIRECTED_ROWS] = '{
        // first tick at time zero: only the last task is overdue from reset
        '{ROW_ITEM,  '0, 32'd0,          1'b1, 1'b1, 3'd5},
        // scan resumes on the last task, nothing due, scan falls back
        '{ROW_ITEM,  '0, 32'd1,          1'b1, 1'b0, 3'd0},
        '{ROW_ITEM,  '0, 32'd3,          1'b1, 1'b1, 3'd0},
        '{ROW_ITEM,  '0, 32'd3,          1'b0, 1'b0, 3'd0},
        '{ROW_ITEM,  '0, 32'd3,          1'b0, 1'b0, 3'd0},
        // several tasks due at once, handed out one per tick
        '{ROW_ITEM,  '0, 32'd700,        1'b0, 1'b0, 3'd0},
        '{ROW_ITEM,  '0, 32'd700,        1'b0, 1'b0, 3'd0},
        '{ROW_ITEM,  '0, 32'd700,        1'b0, 1'b0, 3'd0},
        // all tasks masked off
        '{ROW_WRITE, REG_ENABLE, 32'd0,  1'b0, 1'b0, 3'd0},
        '{ROW_ITEM,  '0, 32'hFFFF_FFFF,  1'b1, 1'b0, 3'd0},
        '{ROW_WRITE, REG_ENABLE, 32'hFFFF_FFFF, 1'b0, 1'b0, 3'd0},
        '{ROW_WRITE, REG_INTERVAL_FIRST, 32'd0, 1'b0, 1'b0, 3'd0},
        '{ROW_WRITE, REG_INTERVAL_LAST, 32'hFFFF_FFFF, 1'b0, 1'b0, 3'd0},
        '{ROW_WRITE, REG_UNUSED, 32'd0,  1'b0, 1'b0, 3'd0},
        '{ROW_ITEM,  '0, 32'hFFFF_FFFF,  1'b0, 1'b0, 3'd0},
        // time wraps past zero
        '{ROW_ITEM,  '0, 32'd0,          1'b0, 1'b0, 3'd0},
        '{ROW_WRITE, REG_INTERVAL_FIRST + 3'd1, 32'h8000_0000, 1'b0, 1'b0, 3'd0},
        '{ROW_WRITE, REG_INTERVAL_FIRST + 3'd2, 32'hFFFF_FFFE, 1'b0, 1'b0, 3'd0},
        '{ROW_WRITE, REG_INTERVAL_FIRST + 3'd3, 32'd1,         1'b0, 1'b0, 3'd0},
        '{ROW_WRITE, REG_INTERVAL_FIRST + 3'd4, 32'd0,         1'b0, 1'b0, 3'd0},
        '{ROW_ITEM,  '0, 32'h8000_0005,  1'b0, 1'b0, 3'd0},
        '{ROW_ITEM,  '0, 32'h7FFF_FFFF,  1'b0, 1'b0, 3'd0},
        '{ROW_ITEM,  '0, 32'h1234_5678,  1'b0, 1'b0, 3'd0},
        '{ROW_ITEM,  '0, 32'hA5A5_A5A5,  1'b0, 1'b0, 3'd0}
    };

    logic              aclk         = 1'b0;
    logic              aresetn      = 1'b0;
    logic              s_valid      = 1'b0;
    logic              s_ready;
    logic [TIME_W-1:0] s_now_ms     = '0;
    logic              m_valid;
    logic              m_ready      = 1'b0;
    logic              m_task_due;
    logic [IDX_W-1:0]  m_task_index;
    logic              cfg_we       = 1'b0;
    logic [ADDR_W-1:0] cfg_addr     = '0;
    logic [TIME_W-1:0] cfg_wdata    = '0;

    // scheduler shadow state
    logic [MAX_TASKS-1:0] enable_q;
    time_array_t          interval_q;
    bit                   launched_q;
    time_word_t           launch_q;
    time_array_t          last_run_q;
    int                   scan_q;

    dispatch_t  pending_q [$];
    int         errors       = 0;
    int         items_sent   = 0;
    int         results_seen = 0;
    int         cycles       = 0;
    time_word_t clock_ms     = '0;

    periodic_task_dispatcher_top dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_now_ms     (s_now_ms),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_task_due   (m_task_due),
        .m_task_index (m_task_index),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata)
    );

    always #2 aclk = ~aclk;

    // Run limit
    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("%0t: run limit reached, %0d results outstanding", $time,
                     pending_q.size());
            $display("periodic_task_dispatcher_top verification failed");
            $finish;
        end
    end

    // Pick the next due task for one tick and update the shadow state
    function automatic dispatch_t dispatch_next(input time_word_t now);
        time_word_t rel;
        dispatch_t  res;
        bit         found;
        res   = '0;
        found = 1'b0;
        if (!launched_q) begin
            launched_q = 1'b1;
            launch_q   = now;
        end
        rel = now - launch_q;
        for (int k = scan_q; k < TASKS; k++) begin
            if (!found && enable_q[k] && time_word_t'(rel - last_run_q[k]) > interval_q[k]) begin
                found         = 1'b1;
                last_run_q[k] = rel;
                scan_q        = k;
                res.due       = 1'b1;
                res.idx       = IDX_W'(k);
            end
        end
        if (!found)
            scan_q = 0;
        return res;
    endfunction

    // Idle length: mostly none, some short, a few long
    function automatic int idle_gap(input bit quiet);
        int r;
        r = $urandom_range(0, 15);
        if (quiet || r < 8)
            return 0;
        else if (r < 14)
            return $urandom_range(1, 3);
        else if (r < 15)
            return $urandom_range(4, 8);
        else
            return $urandom_range(10, 40);
    endfunction

    // Next tick time: mostly small steps, sometimes repeats, jumps and steps back
    function automatic time_word_t next_tick();
        int r;
        r = $urandom_range(0, 63);
        if (r == 0)
            clock_ms = $urandom;
        else if (r == 1)
            clock_ms = clock_ms - $urandom_range(1, 1000);
        else if (r >= 16)
            clock_ms = clock_ms + $urandom_range(1, 3);
        return clock_ms;
    endfunction

    // Register write with shadow update; cfg_we is lowered and the bus left quiet before the task returns
    task automatic write_reg(input logic [ADDR_W-1:0] addr, input time_word_t value);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (addr == REG_ENABLE)
            enable_q = value[MAX_TASKS-1:0];
        else if (addr >= REG_INTERVAL_FIRST && addr <= REG_INTERVAL_LAST)
            interval_q[addr - REG_INTERVAL_FIRST] = value;
        @(posedge aclk);
    endtask

    // One input transfer; the expectation is queued before its result can arrive
    task automatic offer_time(input time_word_t now, input int gap, input bit typed,
                              input dispatch_t typed_res);
        dispatch_t predicted;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid  <= 1'b1;
        s_now_ms <= now;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        predicted = dispatch_next(now);
        pending_q.push_back(typed ? typed_res : predicted);
        items_sent++;
    endtask

    // Stop offering, let every result arrive and the block settle
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (pending_q.size() != 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // Result checking and ready pattern
    always @(posedge aclk) begin : result_side
        static int  stall_left  = 0;
        static int  hold_left   = 0;
        static int  next_hold   = 300;
        static int  mode_left   = 100;
        static bit  ready_quiet = 1'b0;
        dispatch_t  want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (pending_q.size() == 0) begin
                errors++;
                $display("%0t: result due %0b index %0d with nothing expected", $time,
                         m_task_due, m_task_index);
            end else begin
                want = pending_q.pop_front();
                if (m_task_due !== want.due) begin
                    errors++;
                    $display("%0t: task_due expected %0b actual %0b", $time, want.due,
                             m_task_due);
                end
                if (m_task_index !== want.idx) begin
                    errors++;
                    $display("%0t: task_index expected %0d actual %0d", $time, want.idx,
                             m_task_index);
                end
            end
        end
        mode_left--;
        if (mode_left <= 0) begin
            ready_quiet = ($urandom_range(0, 3) == 0);
            mode_left   = $urandom_range(50, 400);
        end
        // long hold-off while the sender keeps offering, so the input stalls
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (aresetn && results_seen >= next_hold && s_valid) begin
            hold_left = HOLD_CYCLES - 1;
            next_hold += 800;
            m_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            stall_left = idle_gap(ready_quiet);
        end
    end

    // Stimulus
    initial begin : stimulus
        int        phase_len;
        bit        send_quiet;
        time_word_t value;
        enable_q   = ENABLE_RESET;
        interval_q = INTERVAL_RESET;
        last_run_q = '0;
        last_run_q[TASKS-1] = LAST_TASK_RESET_RUN;
        launched_q = 1'b0;
        launch_q   = '0;
        scan_q     = 0;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // directed table
        foreach (DIRECTED[i]) begin
            if (DIRECTED[i].kind == ROW_WRITE) begin
                wait_idle();
                write_reg(DIRECTED[i].addr, DIRECTED[i].value);
            end else begin
                offer_time(DIRECTED[i].value, 0, DIRECTED[i].typed,
                           dispatch_t'{DIRECTED[i].due, DIRECTED[i].idx});
            end
        end
        clock_ms = DIRECTED[DIRECTED_ROWS-1].value;

        // random phases, each after random writes to some of the registers
        while (items_sent < TARGET_ITEMS) begin
            wait_idle();
            for (int r = REG_ENABLE; r <= REG_UNUSED; r++) begin
                if ($urandom_range(0, 2) != 0) begin
                    if (r == REG_ENABLE) begin
                        case ($urandom_range(0, 7))
                            0:       value = '0;
                            1:       value = '1;
                            default: value = $urandom;
                        endcase
                    end else begin
                        case ($urandom_range(0, 11))
                            0:       value = '0;
                            1:       value = '1;
                            2:       value = $urandom;
                            3:       value = 32'h8000_0000;
                            default: value = $urandom_range(0, 12);
                        endcase
                    end
                    write_reg(ADDR_W'(r), value);
                end
            end
            phase_len  = $urandom_range(20, 150);
            send_quiet = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < phase_len; n++)
                offer_time(next_tick(), idle_gap(send_quiet), 1'b0, '0);
        end

        wait_idle();
        if (errors == 0)
            $display("periodic_task_dispatcher_top verification clean");
        else
            $display("periodic_task_dispatcher_top verification failed");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/ptd_pkg.sv
rtl/core/periodic_task_dispatcher_top.sv
dv/periodic_task_dispatcher_top_tb.sv
